@@ hdl/hsv_pkg.sv @@
// hsv_pkg: shared types and constants of the hsv to rgb converter
// used by hsv_front, hsv_fifo, hsv_back and hsv_to_rgb; no dependencies
`default_nettype none

package hsv_pkg;

   localparam int NUM_LANES = 3;

   localparam logic [11:0] HUE_FULL    = 12'd3600;
   localparam logic [11:0] HUE_TWO_SEC = 12'd1200;
   localparam logic [11:0] HUE_FOUR_SEC = 12'd2400;
   localparam logic [9:0]  SECTOR_SPAN = 10'd600;
   localparam logic [9:0]  UNIT        = 10'd1000;

   // channel numerator before brightness: 600000 - sat * (600 - g)
   localparam logic [19:0] T_FULL      = 20'd600000;
   // out = round(v * t * 17 / 4e7)
   localparam logic [4:0]  SCALE_NUM   = 5'd17;
   localparam logic [25:0] DIV_DEN     = 26'd40000000;
   localparam logic [24:0] DIV_HALF    = 25'd20000000;
   localparam logic [10:0] RECIP       = 11'd1825;
   localparam int          RECIP_SHIFT = 32;

   typedef enum logic [2:0] {
      SEC_RED_YEL  = 3'd0,
      SEC_YEL_GRN  = 3'd1,
      SEC_GRN_CYN  = 3'd2,
      SEC_CYN_BLU  = 3'd3,
      SEC_BLU_MAG  = 3'd4,
      SEC_MAG_RED  = 3'd5
   } sector_type;

   typedef struct packed {
      logic [9:0] sat;
      logic [9:0] val;
      sector_type sector;
      logic [9:0] frac;
   } hsv_word_type;

endpackage

`default_nettype wire

@@ hdl/hsv_front.sv @@
// hsv_front: clamps saturation and brightness, reduces hue, finds sector and position
// depends on hsv_pkg
`default_nettype none

module hsv_front (
   input  wire logic [11:0]          hue_tenths,
   input  wire logic [9:0]           saturation,
   input  wire logic [9:0]           brightness,
   output hsv_pkg::hsv_word_type     word
);
   import hsv_pkg::*;

   logic [11:0] hue_red;
   logic [11:0] pos;
   logic [9:0]  pos_lo;
   sector_type  sector;
   logic [9:0]  frac;

   always_comb begin
      hue_red = (hue_tenths >= HUE_FULL) ? hue_tenths - HUE_FULL : hue_tenths;

      priority if (hue_red >= HUE_FOUR_SEC) begin
         pos = hue_red - HUE_FOUR_SEC;
      end else if (hue_red >= HUE_TWO_SEC) begin
         pos = hue_red - HUE_TWO_SEC;
      end else begin
         pos = hue_red;
      end

      priority if (hue_red >= 12'd3000) begin
         sector = SEC_MAG_RED;
      end else if (hue_red >= HUE_FOUR_SEC) begin
         sector = SEC_BLU_MAG;
      end else if (hue_red >= 12'd1800) begin
         sector = SEC_CYN_BLU;
      end else if (hue_red >= HUE_TWO_SEC) begin
         sector = SEC_GRN_CYN;
      end else if (hue_red >= 12'(SECTOR_SPAN)) begin
         sector = SEC_YEL_GRN;
      end else begin
         sector = SEC_RED_YEL;
      end

      pos_lo = pos[9:0];
      if (pos >= 12'(SECTOR_SPAN)) begin
         frac = 10'(HUE_TWO_SEC - pos);
      end else begin
         frac = pos_lo;
      end
   end

   assign word.sat    = (saturation > UNIT) ? UNIT : saturation;
   assign word.val    = (brightness > UNIT) ? UNIT : brightness;
   assign word.sector = sector;
   assign word.frac   = frac;

endmodule

`default_nettype wire

@@ hdl/hsv_fifo.sv @@
// hsv_fifo: short queue of classified words between front and back
// depends on hsv_pkg
`default_nettype none

module hsv_fifo #(
   parameter int DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire hsv_pkg::hsv_word_type push_word,
   input  wire logic                 pop,
   output hsv_pkg::hsv_word_type     pop_word,
   output logic                      full,
   output logic                      empty
);
   import hsv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hsv_word_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

@@ hdl/hsv_back.sv @@
// hsv_back: five-stage pipeline, one lane per channel, scales and rounds to 8 bits
// depends on hsv_pkg
`default_nettype none

module hsv_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire hsv_pkg::hsv_word_type in_word,
   output logic                      out_valid,
   output logic [7:0]                out_red,
   output logic [7:0]                out_green,
   output logic [7:0]                out_blue
);
   import hsv_pkg::*;

   logic [4:0]  valid_ff;

   logic [9:0]  lane_dist [NUM_LANES];
   logic [9:0]  rest;
   logic [19:0] sd     [NUM_LANES];

   logic [19:0] t_ff   [NUM_LANES];
   logic [9:0]  val_ff;
   logic [29:0] vt_ff  [NUM_LANES];
   logic [29:0] vt3_ff [NUM_LANES];
   logic [7:0]  qe_ff  [NUM_LANES];
   logic [26:0] r_ff   [NUM_LANES];
   logic [7:0]  q4_ff  [NUM_LANES];
   logic [7:0]  out_ff [NUM_LANES];

   logic [40:0] prod3  [NUM_LANES];
   logic [33:0] rem4   [NUM_LANES];
   logic        ge5    [NUM_LANES];
   logic [25:0] r5     [NUM_LANES];
   logic [8:0]  q5     [NUM_LANES];
   logic        up5    [NUM_LANES];
   logic [8:0]  out_in [NUM_LANES];

   // lane 0 red, 1 green, 2 blue; lane_dist 0 gets chroma, SECTOR_SPAN gets zero
   always_comb begin
      rest = SECTOR_SPAN - in_word.frac;
      unique case (in_word.sector)
         SEC_RED_YEL: begin
            lane_dist[0] = '0;          lane_dist[1] = rest;
            lane_dist[2] = SECTOR_SPAN;
         end
         SEC_YEL_GRN: begin
            lane_dist[0] = rest;        lane_dist[1] = '0;
            lane_dist[2] = SECTOR_SPAN;
         end
         SEC_GRN_CYN: begin
            lane_dist[0] = SECTOR_SPAN; lane_dist[1] = '0;
            lane_dist[2] = rest;
         end
         SEC_CYN_BLU: begin
            lane_dist[0] = SECTOR_SPAN; lane_dist[1] = rest;
            lane_dist[2] = '0;
         end
         SEC_BLU_MAG: begin
            lane_dist[0] = rest;        lane_dist[1] = SECTOR_SPAN;
            lane_dist[2] = '0;
         end
         default: begin
            lane_dist[0] = '0;          lane_dist[1] = SECTOR_SPAN;
            lane_dist[2] = rest;
         end
      endcase
      for (int i = 0; i < NUM_LANES; i++) begin
         sd[i] = 20'(in_word.sat) * 20'(lane_dist[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         prod3[i]  = 41'(vt_ff[i]) * 41'(RECIP);
         rem4[i]   = 34'(vt3_ff[i]) * 34'(SCALE_NUM) - 34'(qe_ff[i]) * 34'(DIV_DEN);
         ge5[i]    = (r_ff[i] >= 27'(DIV_DEN));
         r5[i]     = ge5[i] ? 26'(r_ff[i] - 27'(DIV_DEN)) : r_ff[i][25:0];
         q5[i]     = 9'(q4_ff[i]) + 9'(ge5[i]);
         up5[i]    = (r5[i] > 26'(DIV_HALF)) || ((r5[i] == 26'(DIV_HALF)) && q5[i][0]);
         out_in[i] = q5[i] + 9'(up5[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= in_word.val;
      for (int i = 0; i < NUM_LANES; i++) begin
         t_ff[i]   <= T_FULL - sd[i];
         vt_ff[i]  <= 30'(val_ff) * 30'(t_ff[i]);
         vt3_ff[i] <= vt_ff[i];
         qe_ff[i]  <= prod3[i][RECIP_SHIFT +: 8];
         q4_ff[i]  <= qe_ff[i];
         r_ff[i]   <= rem4[i][26:0];
         out_ff[i] <= out_in[i][7:0];
      end
   end

   assign out_valid = valid_ff[4];
   assign out_red   = out_ff[0];
   assign out_green = out_ff[1];
   assign out_blue  = out_ff[2];

endmodule

`default_nettype wire

@@ hdl/hsv_to_rgb.sv @@
// hsv_to_rgb: one hsv word per clock in while busy is low, one 8-bit rgb word per clock out
// rsp_strobe rises once an accepted word has passed the queue and the hsv_back pipeline
// throughput: one word per cycle when QUEUE_DEPTH > 1; the back pipeline never stalls, so busy stays low
// reset: synchronous, active high, empties the queue and the pipeline valid bits
// depends on hsv_pkg, hsv_front, hsv_fifo, hsv_back
`default_nettype none

module hsv_to_rgb #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_hue_tenths,
   input  wire logic [9:0]  req_saturation,
   input  wire logic [9:0]  req_brightness,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue
);
   import hsv_pkg::*;

   hsv_word_type front_word;
   hsv_word_type queue_word;
   logic         queue_full;
   logic         queue_empty;
   logic         accept;

   assign accept = start && !busy;
   assign busy   = queue_full;

   hsv_front u_front (
      .hue_tenths (req_hue_tenths),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .word       (front_word)
   );

   hsv_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (front_word),
      .pop       (!queue_empty),
      .pop_word  (queue_word),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   hsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!queue_empty),
      .in_word   (queue_word),
      .out_valid (rsp_strobe),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   // queue drains every cycle so, with QUEUE_DEPTH > 1, it never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue filled");

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_strobe)
      else $error("accepted word produced no result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 6))
      else $error("result without accepted word");

endmodule

`default_nettype wire

@@ bench/rgb_checker.sv @@
// rgb_checker: watches the hsv input channel and the rgb result channel of hsv_to_rgb,
// predicts each rgb word and compares it field by field
// depends on hsv_pkg for the sector enum
`timescale 1ns / 100ps

module rgb_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [11:0] req_hue_tenths,
   input  wire logic [9:0]  req_saturation,
   input  wire logic [9:0]  req_brightness,
   input  wire logic        rsp_strobe,
   input  wire logic [7:0]  rsp_red,
   input  wire logic [7:0]  rsp_green,
   input  wire logic [7:0]  rsp_blue,
   output int               mismatches,
   output int               pending,
   output int               compared
);
   import hsv_pkg::*;

   localparam longint unsigned FULL_TURN = 3600;
   localparam longint unsigned SPAN      = 600;
   localparam longint unsigned ONE       = 1000;
   localparam longint unsigned COMMON    = 600000000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_word_type;

   rgb_word_type expected_rgb[$];
   int        mismatch_total = 0;
   int        compare_total = 0;

   initial begin
      mismatches = 0;
      pending    = 0;
      compared   = 0;
   end

   // channel numerator over COMMON, times 255, rounded half to even
   function automatic logic [7:0] scale_channel(longint unsigned num);
      longint unsigned scaled, quot, rem;
      scaled = num * 255;
      quot   = scaled / COMMON;
      rem    = scaled % COMMON;
      if (2 * rem > COMMON || (2 * rem == COMMON && quot[0]))
         quot++;
      return quot[7:0];
   endfunction

   function automatic rgb_word_type predict_rgb(logic [11:0] hue, logic [9:0] sat,
                                                logic [9:0] bri);
      longint unsigned h, s, v, pos, f, chroma, inter, offset;
      longint unsigned r_num, g_num, b_num;
      sector_type      sec;
      rgb_word_type    word;
      h = hue;
      s = sat;
      v = bri;
      if (h >= FULL_TURN)
         h -= FULL_TURN;
      if (s > ONE)
         s = ONE;
      if (v > ONE)
         v = ONE;
      sec    = sector_type'(h / SPAN);
      pos    = h % (2 * SPAN);
      f      = (pos >= SPAN) ? (2 * SPAN - pos) : pos;
      chroma = v * s * SPAN;
      inter  = v * s * f;
      offset = v * (ONE - s) * SPAN;
      case (sec)
         SEC_RED_YEL: begin r_num = chroma; g_num = inter;  b_num = 0;      end
         SEC_YEL_GRN: begin r_num = inter;  g_num = chroma; b_num = 0;      end
         SEC_GRN_CYN: begin r_num = 0;      g_num = chroma; b_num = inter;  end
         SEC_CYN_BLU: begin r_num = 0;      g_num = inter;  b_num = chroma; end
         SEC_BLU_MAG: begin r_num = inter;  g_num = 0;      b_num = chroma; end
         default:     begin r_num = chroma; g_num = 0;      b_num = inter;  end
      endcase
      word.red   = scale_channel(r_num + offset);
      word.green = scale_channel(g_num + offset);
      word.blue  = scale_channel(b_num + offset);
      return word;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_total < 40)
         $display("rgb_checker: %s got %0d want %0d at %0t", what, got, want, $time);
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      rgb_word_type want;
      if (!reset) begin
         if (start && !busy)
            expected_rgb.push_back(predict_rgb(req_hue_tenths, req_saturation,
                                               req_brightness));
         if (rsp_strobe) begin
            if (expected_rgb.size() == 0) begin
               report_mismatch("rgb word with none expected, red", rsp_red, -1);
            end else begin
               want = expected_rgb.pop_front();
               compare_total++;
               if (rsp_red !== want.red)
                  report_mismatch("red", rsp_red, want.red);
               if (rsp_green !== want.green)
                  report_mismatch("green", rsp_green, want.green);
               if (rsp_blue !== want.blue)
                  report_mismatch("blue", rsp_blue, want.blue);
            end
         end
      end
      mismatches <= mismatch_total;
      compared   <= compare_total;
      pending    <= expected_rgb.size();
   end

endmodule

@@ bench/tb.sv @@
// tb: drives hsv words into hsv_to_rgb with random gaps and gives the verdict
// depends on hsv_to_rgb, hsv_pkg and rgb_checker
`timescale 1ns / 100ps

module tb;

   localparam int RANDOM_WORDS = 1450;
   localparam int IDLE_LIMIT   = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_hue_tenths;
   logic [9:0]  req_saturation;
   logic [9:0]  req_brightness;
   logic        rsp_strobe;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   int          mismatches;
   int          pending;
   int          compared;
   int          words_sent = 0;
   int          idle_cycles = 0;

   hsv_to_rgb uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue_tenths (req_hue_tenths),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   rgb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue_tenths (req_hue_tenths),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .mismatches     (mismatches),
      .pending        (pending),
      .compared       (compared)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   task automatic send_word(logic [11:0] hue, logic [9:0] sat, logic [9:0] bri, int gap);
      req_hue_tenths <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      start          <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      words_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_gap(int index);
      int roll;
      roll = $urandom_range(0, 99);
      if ((index % 256) < 48 || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      logic [11:0] hue;
      logic [9:0]  sat;
      logic [9:0]  bri;
      int          kind;
      start          = 1'b0;
      req_hue_tenths = '0;
      req_saturation = '0;
      req_brightness = '0;
      reset          = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sector edges at full saturation and brightness
      send_word(12'd0,    10'd1000, 10'd1000, 0);
      send_word(12'd599,  10'd1000, 10'd1000, 0);
      send_word(12'd600,  10'd1000, 10'd1000, 1);
      send_word(12'd1199, 10'd1000, 10'd1000, 0);
      send_word(12'd1200, 10'd1000, 10'd1000, 0);
      send_word(12'd1800, 10'd1000, 10'd1000, 2);
      send_word(12'd2400, 10'd1000, 10'd1000, 0);
      send_word(12'd3000, 10'd1000, 10'd1000, 0);
      send_word(12'd3599, 10'd1000, 10'd1000, 0);
      // hue wrap and clamping
      send_word(12'd3600, 10'd1000, 10'd1000, 0);
      send_word(12'd4095, 10'd1023, 10'd1023, 3);
      send_word(12'd1500, 10'd1001, 10'd1001, 0);
      send_word(12'd900,  10'd1023, 10'd500,  0);
      send_word(12'd4095, 10'd0,    10'd0,    0);
      send_word(12'd0,    10'd0,    10'd0,    1);
      send_word(12'd300,  10'd0,    10'd1000, 0);
      send_word(12'd2100, 10'd500,  10'd0,    0);
      // exact halves that round to even, then a mid-range word and a clamped word
      send_word(12'd2700, 10'd0,    10'd100,  0);
      send_word(12'd3300, 10'd0,    10'd300,  0);
      send_word(12'd0,    10'd0,    10'd500,  0);
      send_word(12'd2048, 10'd512,  10'd512,  0);
      send_word(12'd1000, 10'd1023, 10'd1023, 5);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         kind = $urandom_range(0, 9);
         hue  = 12'($urandom_range(0, 4095));
         sat  = 10'($urandom_range(0, 1023));
         bri  = 10'($urandom_range(0, 1023));
         case (kind)
            6: hue = 12'($urandom_range(1, 6) * 600 + $urandom_range(0, 4) - 2);
            7: hue = 12'($urandom_range(3600, 4095));
            8: begin
               sat = 10'($urandom_range(990, 1023));
               bri = 10'($urandom_range(990, 1023));
            end
            9: begin
               sat = 10'($urandom_range(0, 20));
               bri = 10'($urandom_range(0, 20));
            end
            default: ;
         endcase
         send_word(hue, sat, bri, pick_gap(i));
      end
      start <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("tb: %0d hsv words sent, %0d rgb words compared", words_sent, compared);
      $display("tb: covered sector edges, hue wrap, clamping and half-to-even rounding");
      if (mismatches == 0 && pending == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

@@ hsv_to_rgb.f @@
hdl/hsv_pkg.sv
hdl/hsv_front.sv
hdl/hsv_fifo.sv
hdl/hsv_back.sv
hdl/hsv_to_rgb.sv
bench/rgb_checker.sv
bench/tb.sv
